>>> sv/bbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types, constants and the pixel interpolation function of the
// GRBG bilinear demosaic.
// ----------------------------------------------------------------------------
package bbd_pkg;

  localparam int SAMPLE_BITS   = 8;
  localparam int SUM2_BITS     = SAMPLE_BITS + 1;
  localparam int SUM4_BITS     = SAMPLE_BITS + 2;
  localparam int DEF_MAX_WIDTH = 4096;
  localparam int WIDTH_BITS    = 13;
  localparam int ROW_BITS      = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int RESET_WIDTH   = 640;
  localparam logic [ROW_BITS-1:0] RESET_HEIGHT = 16'd480;
  localparam logic [ROW_BITS-1:0] MIN_HEIGHT   = 16'd2;

  // Result queue
  localparam int OUT_DEPTH = 4;
  localparam int OPTR_BITS = $clog2(OUT_DEPTH);
  localparam int OCNT_BITS = $clog2(OUT_DEPTH + 1);

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  typedef enum logic [0:0] {
    CMD_SAMPLE = 1'b0,
    CMD_DRAIN  = 1'b1
  } command_t;

  // One line buffer entry: the two previous rows at one column.
  typedef struct packed {
    sample_t older;
    sample_t newer;
  } line_word_t;

  // One window column, top to bottom.
  typedef struct packed {
    sample_t top;
    sample_t mid;
    sample_t bot;
  } column_t;

  // Per-item control carried from accept into the memory read stage.
  typedef struct packed {
    logic    valid;
    logic    drain;
    logic    emit;        // at least one pixel
    logic    pair;        // end of row: second pixel for the last column
    logic    first_col;   // left neighbor is mirrored
    logic    top_mirror;  // top neighbor is mirrored (output row 0)
    logic    row_odd;     // parity of the output row
    logic    col_odd;     // parity of the first output column
    logic    last_col;
    sample_t sample;
  } step_t;

  typedef struct packed {
    sample_t red;
    sample_t green;
    sample_t blue;
    logic    end_of_line;
    logic    end_of_frame;
    logic    last_in_run;
  } pixel_t;

  function automatic column_t mirror_top(column_t x, logic mirror);
    column_t y;
    y = x;
    if (mirror) y.top = x.bot;
    return y;
  endfunction

  // Drain columns reuse the older row as the row below.
  function automatic column_t drain_column(line_word_t w);
    column_t y;
    y.top = w.older;
    y.mid = w.newer;
    y.bot = w.older;
    return y;
  endfunction

  function automatic pixel_t emit_pixel(column_t l, column_t c, column_t r,
                                        logic rodd, logic codd,
                                        logic eol, logic eof, logic last);
    logic [SUM4_BITS-1:0] cross_sum;
    logic [SUM4_BITS-1:0] diag;
    logic [SUM2_BITS-1:0] vert;
    logic [SUM2_BITS-1:0] horz;
    pixel_t p;
    cross_sum = SUM4_BITS'(c.top) + SUM4_BITS'(l.mid) + SUM4_BITS'(r.mid) +
                SUM4_BITS'(c.bot);
    diag  = SUM4_BITS'(l.top) + SUM4_BITS'(r.top) + SUM4_BITS'(l.bot) + SUM4_BITS'(r.bot);
    vert  = SUM2_BITS'(c.top) + SUM2_BITS'(c.bot);
    horz  = SUM2_BITS'(l.mid) + SUM2_BITS'(r.mid);
    if (rodd == codd) begin
      p.green = c.mid;
      if (!rodd) begin
        p.red  = horz[SUM2_BITS-1:1];
        p.blue = vert[SUM2_BITS-1:1];
      end else begin
        p.red  = vert[SUM2_BITS-1:1];
        p.blue = horz[SUM2_BITS-1:1];
      end
    end else if (!rodd) begin
      p.red   = c.mid;
      p.green = cross_sum[SUM4_BITS-1:2];
      p.blue  = diag[SUM4_BITS-1:2];
    end else begin
      p.blue  = c.mid;
      p.green = cross_sum[SUM4_BITS-1:2];
      p.red   = diag[SUM4_BITS-1:2];
    end
    p.end_of_line  = eol;
    p.end_of_frame = eof;
    p.last_in_run  = last;
    return p;
  endfunction

endpackage

>>> sv/bbd_line_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_line_mem
// Two-row line buffer: one write port, two registered read ports, with
// write-to-read forwarding on an address match in the same cycle.
// ----------------------------------------------------------------------------
module bbd_line_mem import bbd_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  line_word_t               wr_data,
  output line_word_t               rd_data_a,
  output line_word_t               rd_data_b
);

  line_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // forward the word being written so back-to-back columns see fresh data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem[rd_addr_a];
      rd_data_b <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem[rd_addr_b];
    end
  end

endmodule

>>> sv/bbd_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_window
// Read stage: builds the 3x3 neighborhood from the window registers and the
// line buffer words, and interpolates up to two pixels per item.
// ----------------------------------------------------------------------------
module bbd_window import bbd_pkg::*; (
  input  logic       clk,
  input  step_t      s1,
  input  line_word_t rd_a,
  input  line_word_t rd_b,
  output pixel_t     pix0,
  output pixel_t     pix1,
  output logic [1:0] push_count
);

  // two previous window columns; the newest comes from memory + sample
  column_t win_l;
  column_t win_m;

  column_t col_new;
  column_t col_a;
  column_t col_b;
  column_t w0;
  column_t w1;
  column_t w2;
  column_t drain_left;
  pixel_t  pix_sample;
  pixel_t  pix_drain;

  always_comb begin
    col_new.top = rd_a.older;
    col_new.mid = rd_a.newer;
    col_new.bot = s1.sample;
    col_a = drain_column(rd_a);
    col_b = drain_column(rd_b);

    w0 = mirror_top(win_l, s1.top_mirror);
    w1 = mirror_top(win_m, s1.top_mirror);
    w2 = mirror_top(col_new, s1.top_mirror);

    drain_left = s1.first_col ? col_b : win_m;

    pix_sample = emit_pixel(s1.first_col ? w2 : w0, w1, w2, s1.row_odd, s1.col_odd,
                            1'b0, 1'b0, !s1.last_col);
    pix_drain  = emit_pixel(drain_left, col_a, col_b, s1.row_odd, s1.col_odd,
                            s1.last_col, s1.last_col, 1'b1);

    pix0 = s1.drain ? pix_drain : pix_sample;
    // last column of the row mirrors its left neighbor to the right
    pix1 = emit_pixel(w1, w2, w1, s1.row_odd, !s1.col_odd, 1'b1, 1'b0, 1'b1);

    if (!s1.valid || !s1.emit) push_count = 2'd0;
    else if (s1.pair)          push_count = 2'd2;
    else                       push_count = 2'd1;
  end

  always_ff @(posedge clk) begin
    if (s1.valid) begin
      win_l <= win_m;
      win_m <= s1.drain ? col_a : col_new;
    end
  end

endmodule

>>> sv/bbd_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_out_fifo
// Small result queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module bbd_out_fifo import bbd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           push_count,
  input  pixel_t               push0,
  input  pixel_t               push1,
  input  logic                 stall,
  output logic                 valid,
  output pixel_t               head,
  output logic [OCNT_BITS-1:0] count
);

  pixel_t               entries [OUT_DEPTH];
  logic [OPTR_BITS-1:0] wr_ptr;
  logic [OPTR_BITS-1:0] rd_ptr;
  logic                 pop;

  assign valid = count != '0;
  assign head  = entries[rd_ptr];
  assign pop   = valid && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OPTR_BITS'(push_count);
      rd_ptr <= rd_ptr + OPTR_BITS'(pop);
      count  <= count + OCNT_BITS'(push_count) - OCNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) entries[wr_ptr] <= push0;
    if (push_count == 2'd2) entries[wr_ptr + OPTR_BITS'(1)] <= push1;
  end

endmodule

>>> sv/bayer_bilinear_demosaic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_unit
// Streaming bilinear demosaic of a GRBG Bayer mosaic, 3x3 neighborhood.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one transaction per raster sample
//   (command = CMD_SAMPLE) or, after the last row, one drain tick per column
//   (command = CMD_DRAIN). Pixel (r,c) leaves when sample (r+1,c+1) arrives;
//   the last sample of a row also releases the row's last pixel.
//   Output channel (out_valid / out_stall): one RGB pixel per transaction.
//   Config channel (cfg_valid / cfg_ready): image_width and image_height,
//   written between frames; cfg_ready is always high.
// Timing:
//   An accepted item reads the line buffer at its column on the accept edge,
//   which also registers its control; from these registers its pixels are
//   written to the four-deep output queue, which sets out_valid and in_stall.
//   Throughput is one item per cycle while in_stall is low. An end-of-row
//   item past row 0 yields two pixels; the single output port drains one per
//   cycle while out_stall is low, so the input stalls after each such item.
// Reset: clears counters, queue and the pipeline valid; registers return to
//   640 x 480. Line buffer contents stay undefined until written.
// Receiver stall: the queue holds results; once it cannot take a worst-case
//   item, in_stall rises. No result is dropped.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic_unit import bbd_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  // input stream
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     command,
  input  logic [SAMPLE_BITS-1:0]   raw_sample,
  // output stream
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [SAMPLE_BITS-1:0]   red,
  output logic [SAMPLE_BITS-1:0]   green,
  output logic [SAMPLE_BITS-1:0]   blue,
  output logic                     end_of_line,
  output logic                     end_of_frame,
  output logic                     last_in_run,
  // register writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [0:0]               cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RESET_WLAST = ((RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH) - 1;

  // --- configuration -------------------------------------------------------
  logic [CW-1:0]       width_last;      // effective width minus one
  logic [CW-1:0]       width_last_next;
  logic [ROW_BITS-1:0] height_eff;
  logic [ROW_BITS-1:0] height_eff_next;
  logic [31:0]         width_req;

  assign cfg_ready = 1'b1;

  // clamp width into [2, MAX_WIDTH], height to at least 2
  always_comb begin
    width_req = 32'(cfg_data[WIDTH_BITS-1:0]);
    if (width_req < 32'd2) width_req = 32'd2;
    if (width_req > 32'(MAX_WIDTH)) width_req = 32'(MAX_WIDTH);
    width_last_next = CW'(width_req - 32'd1);
    height_eff_next = (cfg_data < MIN_HEIGHT) ? MIN_HEIGHT : cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_last <= CW'(RESET_WLAST);
      height_eff <= RESET_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_last <= width_last_next;
        REG_IMAGE_HEIGHT: height_eff <= height_eff_next;
      endcase
    end
  end

  // --- accept stage: position counters and item decode -------------------
  logic [CW-1:0]       column_count;
  logic [ROW_BITS-1:0] row_count;
  logic [CW-1:0]       drain_count;

  logic          accept;
  logic          is_drain;
  logic          frame_done;
  logic          drain_go;
  logic          sample_go;
  logic          endrow;
  logic          drain_last;
  logic [CW-1:0] drain_right;
  logic [CW-1:0] rd_addr_a;
  step_t         step_next;
  step_t         s1;
  logic [CW-1:0] s1_col;

  assign accept      = in_valid && !in_stall;
  assign is_drain    = command == CMD_DRAIN;
  assign frame_done  = row_count >= height_eff;
  // drain ticks mid-frame and samples after the last row are swallowed
  assign drain_go    = is_drain && frame_done;
  assign sample_go   = !is_drain && !frame_done;
  assign endrow      = column_count >= width_last;
  assign drain_last  = drain_count >= width_last;
  // at the right edge the right neighbor mirrors to the left one
  assign drain_right = drain_last ? drain_count - CW'(1) : drain_count + CW'(1);
  assign rd_addr_a   = is_drain ? drain_count : column_count;

  always_comb begin
    step_next            = '0;
    step_next.valid      = accept && (drain_go || sample_go);
    step_next.drain      = is_drain;
    step_next.emit       = is_drain || (row_count != '0 && column_count != '0);
    step_next.pair       = !is_drain && row_count != '0 && column_count != '0 && endrow;
    step_next.first_col  = is_drain ? (drain_count == '0) : (column_count == CW'(1));
    step_next.top_mirror = row_count == ROW_BITS'(1);
    // drain emits row h-1, samples emit row-1
    step_next.row_odd    = is_drain ? !height_eff[0] : !row_count[0];
    step_next.col_odd    = is_drain ? drain_count[0] : !column_count[0];
    step_next.last_col   = is_drain ? drain_last : endrow;
    step_next.sample     = raw_sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      drain_count  <= '0;
    end else if (accept) begin
      if (drain_go) begin
        if (drain_last) begin
          column_count <= '0;
          row_count    <= '0;
          drain_count  <= '0;
        end else begin
          drain_count <= drain_count + CW'(1);
        end
      end else if (sample_go) begin
        if (endrow) begin
          column_count <= '0;
          row_count    <= row_count + ROW_BITS'(1);
          drain_count  <= '0;
        end else begin
          column_count <= column_count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1 <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    s1_col <= column_count;
  end

  // --- line buffer: read on accept, write back in the cycle after -----------
  line_word_t rd_a;
  line_word_t rd_b;
  line_word_t wr_data;
  logic       wr_en;

  assign wr_en         = s1.valid && !s1.drain;
  assign wr_data.older = rd_a.newer;
  assign wr_data.newer = s1.sample;

  bbd_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (drain_right),
    .wr_en     (wr_en),
    .wr_addr   (s1_col),
    .wr_data   (wr_data),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // --- neighborhood and interpolation --------------------------------------
  pixel_t     pix0;
  pixel_t     pix1;
  logic [1:0] push_count;

  bbd_window u_window (
    .clk        (clk),
    .s1         (s1),
    .rd_a       (rd_a),
    .rd_b       (rd_b),
    .pix0       (pix0),
    .pix1       (pix1),
    .push_count (push_count)
  );

  // --- output queue ---------------------------------------------------------
  pixel_t               head;
  logic [OCNT_BITS-1:0] fifo_count;

  bbd_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (pix0),
    .push1      (pix1),
    .stall      (out_stall),
    .valid      (out_valid),
    .head       (head),
    .count      (fifo_count)
  );

  // room for what is in flight plus a two-pixel item
  assign in_stall = (4'(fifo_count) + 4'(push_count) + 4'd2) > 4'(OUT_DEPTH);

  assign red          = head.red;
  assign green        = head.green;
  assign blue         = head.blue;
  assign end_of_line  = head.end_of_line;
  assign end_of_frame = head.end_of_frame;
  assign last_in_run  = head.last_in_run;

endmodule

>>> sv/bbd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_checker
// Port-level checks of the demosaic output stream, bound to the top level.
// ----------------------------------------------------------------------------
module bbd_checker import bbd_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [SAMPLE_BITS-1:0] red,
  input logic [SAMPLE_BITS-1:0] green,
  input logic [SAMPLE_BITS-1:0] blue,
  input logic                   end_of_line,
  input logic                   end_of_frame,
  input logic                   last_in_run
);

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({red, green, blue, end_of_line, end_of_frame, last_in_run}))
    else $error("stalled output transaction changed");

  // first pixel of an end-of-row pair is never the row end
  a_pair_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_in_run |-> !end_of_line && !end_of_frame)
    else $error("non-final result flagged as line or frame end");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_frame |-> end_of_line && last_in_run)
    else $error("frame end without line end");

endmodule

bind bayer_bilinear_demosaic_unit bbd_checker u_checker (.*);
